FILE: sv/sbag_pkg.sv
// Shared constants, register codes and structs of the stretch blit alpha gate block.
`timescale 1ns / 1ps

package sbag_pkg;

  // Coordinate and fixed-point sizes
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int SIZE_W     = COORD_BITS + 1;
  localparam int SURF_W     = 13;
  localparam int PIX_W      = 32;
  localparam int ADDR_W     = 24;
  localparam int ALPHA_W    = 8;
  localparam int ALPHA_LSB  = 24;
  localparam int OFS_W      = 17;
  localparam int QUO_W      = SIZE_W + FRAC_BITS;
  localparam int ACC_W      = QUO_W + 1;

  // APB register file
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_SRC_W     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SRC_H     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DST_W     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DST_H     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_THR = 3'd4;

  localparam logic [SURF_W-1:0]  RST_SRC_W     = 13'd640;
  localparam logic [SURF_W-1:0]  RST_SRC_H     = 13'd480;
  localparam logic [SURF_W-1:0]  RST_DST_W     = 13'd640;
  localparam logic [SURF_W-1:0]  RST_DST_H     = 13'd480;
  localparam logic [ALPHA_W-1:0] RST_ALPHA_THR = 8'd255;

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic [SURF_W-1:0]  src_w;
    logic [SURF_W-1:0]  src_h;
    logic [SURF_W-1:0]  dst_w;
    logic [SURF_W-1:0]  dst_h;
    logic [ALPHA_W-1:0] alpha_thr;
  } cfg_t;

  typedef struct packed {
    logic                  operation;
    logic [COORD_BITS-1:0] src_rect_x;
    logic [COORD_BITS-1:0] src_rect_y;
    logic [SIZE_W-1:0]     src_rect_w;
    logic [SIZE_W-1:0]     src_rect_h;
    logic [COORD_BITS-1:0] dst_rect_x;
    logic [COORD_BITS-1:0] dst_rect_y;
    logic [SIZE_W-1:0]     dst_rect_w;
    logic [SIZE_W-1:0]     dst_rect_h;
    logic [PIX_W-1:0]      pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic              src_addr_valid;
    logic [ADDR_W-1:0] dst_addr;
    logic              write_enable;
    logic [PIX_W-1:0]  pixel_out;
    logic              last;
    logic              rejected;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_start;
    logic start_ok;
    logic div_busy;
  } sts_t;

endpackage

FILE: sv/sbag_in_if.sv
// Input channel: valid/ready handshake with start and pixel fields.
`timescale 1ns / 1ps

interface sbag_in_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [sbag_pkg::COORD_BITS-1:0] src_rect_x;
  logic [sbag_pkg::COORD_BITS-1:0] src_rect_y;
  logic [sbag_pkg::SIZE_W-1:0]     src_rect_w;
  logic [sbag_pkg::SIZE_W-1:0]     src_rect_h;
  logic [sbag_pkg::COORD_BITS-1:0] dst_rect_x;
  logic [sbag_pkg::COORD_BITS-1:0] dst_rect_y;
  logic [sbag_pkg::SIZE_W-1:0]     dst_rect_w;
  logic [sbag_pkg::SIZE_W-1:0]     dst_rect_h;
  logic [sbag_pkg::PIX_W-1:0]      pixel_in;

  modport source (
    output valid, operation, src_rect_x, src_rect_y, src_rect_w, src_rect_h,
           dst_rect_x, dst_rect_y, dst_rect_w, dst_rect_h, pixel_in,
    input  ready
  );

  modport sink (
    input  valid, operation, src_rect_x, src_rect_y, src_rect_w, src_rect_h,
           dst_rect_x, dst_rect_y, dst_rect_w, dst_rect_h, pixel_in,
    output ready
  );
endinterface

FILE: sv/sbag_out_if.sv
// Result channel: valid/ready handshake with address, gate and pixel fields.
`timescale 1ns / 1ps

interface sbag_out_if;
  logic                        valid;
  logic                        ready;
  logic [sbag_pkg::ADDR_W-1:0] src_addr;
  logic                        src_addr_valid;
  logic [sbag_pkg::ADDR_W-1:0] dst_addr;
  logic                        write_enable;
  logic [sbag_pkg::PIX_W-1:0]  pixel_out;
  logic                        last;
  logic                        rejected;

  modport source (
    output valid, src_addr, src_addr_valid, dst_addr, write_enable, pixel_out,
           last, rejected,
    input  ready
  );

  modport sink (
    input  valid, src_addr, src_addr_valid, dst_addr, write_enable, pixel_out,
           last, rejected,
    output ready
  );
endinterface

FILE: sv/sbag_cfg.sv
// APB register file holding surface sizes and the alpha threshold.
`timescale 1ns / 1ps

module sbag_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sbag_pkg::PADDR_W-1:0] paddr,
  input  logic [sbag_pkg::PDATA_W-1:0] pwdata,
  output logic [sbag_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output sbag_pkg::cfg_t               cfg
);

  sbag_pkg::cfg_t                  cfg_r;
  logic [sbag_pkg::REG_IDX_W-1:0]  idx;
  logic                            wr;

  assign pready = 1'b1;
  assign idx    = paddr[sbag_pkg::PADDR_W-1:2];
  assign wr     = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_w     <= sbag_pkg::RST_SRC_W;
      cfg_r.src_h     <= sbag_pkg::RST_SRC_H;
      cfg_r.dst_w     <= sbag_pkg::RST_DST_W;
      cfg_r.dst_h     <= sbag_pkg::RST_DST_H;
      cfg_r.alpha_thr <= sbag_pkg::RST_ALPHA_THR;
    end else if (wr) begin
      unique case (idx)
        sbag_pkg::REG_SRC_W:     cfg_r.src_w     <= pwdata[sbag_pkg::SURF_W-1:0];
        sbag_pkg::REG_SRC_H:     cfg_r.src_h     <= pwdata[sbag_pkg::SURF_W-1:0];
        sbag_pkg::REG_DST_W:     cfg_r.dst_w     <= pwdata[sbag_pkg::SURF_W-1:0];
        sbag_pkg::REG_DST_H:     cfg_r.dst_h     <= pwdata[sbag_pkg::SURF_W-1:0];
        sbag_pkg::REG_ALPHA_THR: cfg_r.alpha_thr <= pwdata[sbag_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sbag_pkg::REG_SRC_W:     prdata = sbag_pkg::PDATA_W'(cfg_r.src_w);
      sbag_pkg::REG_SRC_H:     prdata = sbag_pkg::PDATA_W'(cfg_r.src_h);
      sbag_pkg::REG_DST_W:     prdata = sbag_pkg::PDATA_W'(cfg_r.dst_w);
      sbag_pkg::REG_DST_H:     prdata = sbag_pkg::PDATA_W'(cfg_r.dst_h);
      sbag_pkg::REG_ALPHA_THR: prdata = sbag_pkg::PDATA_W'(cfg_r.alpha_thr);
      default:                 prdata = '0;
    endcase
  end

endmodule

FILE: sv/sbag_div.sv
// Two-lane restoring divider, one quotient bit per cycle, for the step ratios.
`timescale 1ns / 1ps

module sbag_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [1:0][sbag_pkg::QUO_W-1:0]      num,
  input  logic [1:0][sbag_pkg::SIZE_W-1:0]     den,
  output logic                                 busy,
  output logic [1:0][sbag_pkg::QUO_W-1:0]      quo
);

  localparam int CNT_W = $clog2(sbag_pkg::QUO_W + 1);

  logic [CNT_W-1:0]              cnt_r;
  logic                          busy_r;
  logic [sbag_pkg::QUO_W-1:0]    q_r     [2];
  logic [sbag_pkg::QUO_W-1:0]    q_nxt   [2];
  logic [sbag_pkg::SIZE_W-1:0]   rem_r   [2];
  logic [sbag_pkg::SIZE_W-1:0]   rem_nxt [2];
  logic [sbag_pkg::SIZE_W-1:0]   den_r   [2];
  logic [sbag_pkg::SIZE_W:0]     trial   [2];
  logic                          fit     [2];

  // Quotient bits shift in where dividend bits shift out.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i]   = {rem_r[i], q_r[i][sbag_pkg::QUO_W-1]};
      fit[i]     = trial[i] >= {1'b0, den_r[i]};
      rem_nxt[i] = fit[i] ? sbag_pkg::SIZE_W'(trial[i] - {1'b0, den_r[i]})
                          : trial[i][sbag_pkg::SIZE_W-1:0];
      q_nxt[i]   = {q_r[i][sbag_pkg::QUO_W-2:0], fit[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(sbag_pkg::QUO_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      if (start) begin
        q_r[i]   <= num[i];
        rem_r[i] <= '0;
        den_r[i] <= den[i];
      end else if (busy_r) begin
        q_r[i]   <= q_nxt[i];
        rem_r[i] <= rem_nxt[i];
      end
    end
  end

  assign busy   = busy_r;
  assign quo[0] = q_r[0];
  assign quo[1] = q_r[1];

  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && (cnt_r == CNT_W'(sbag_pkg::QUO_W)))
    else $error("divider did not load on start");

  a_runs_out: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start && (cnt_r > CNT_W'(1)) |=> busy_r)
    else $error("divider stopped early");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (cnt_r == '0))
    else $error("divider idle with count left");

endmodule

FILE: sv/sbag_dpath.sv
// Datapath: bounds check, rectangle and stepper state, address multipliers, result register.
`timescale 1ns / 1ps

module sbag_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  sbag_pkg::cfg_t      cfg,
  input  sbag_pkg::in_item_t  in_item,
  input  sbag_pkg::cmd_t      cmd,
  output sbag_pkg::sts_t      sts,
  output sbag_pkg::out_item_t out_item
);

  localparam int CB    = sbag_pkg::COORD_BITS;
  localparam int SW    = sbag_pkg::SIZE_W;
  localparam int FB    = sbag_pkg::FRAC_BITS;
  localparam int END_W = ((SW > sbag_pkg::SURF_W) ? SW : sbag_pkg::SURF_W) + 1;
  localparam int SROW_W = ((CB > sbag_pkg::OFS_W) ? CB : sbag_pkg::OFS_W) + 1;
  localparam int SMUL_W = SROW_W + sbag_pkg::SURF_W;
  localparam int DROW_W = ((CB > SW) ? CB : SW) + 1;
  localparam int DMUL_W = DROW_W + sbag_pkg::SURF_W;
  localparam int ACC_W  = sbag_pkg::ACC_W;

  // Blit state
  logic                       active_r;
  logic [CB-1:0]              src_x_r, src_y_r, dst_x_r, dst_y_r;
  logic [SW-1:0]              last_col_r, last_row_r;
  logic [FB-1:0]              acc_x_r, acc_y_r;
  logic [sbag_pkg::OFS_W-1:0] src_col_r, src_row_r;
  logic [SW-1:0]              col_cnt_r, row_cnt_r;

  // Result of the accepted transaction, completed in the output step
  logic                         res_src_valid_r, res_rej_r, res_last_r, res_we_r;
  logic [sbag_pkg::ADDR_W-1:0]  res_dst_r;
  logic [sbag_pkg::PIX_W-1:0]   res_pix_r;
  sbag_pkg::out_item_t          out_r;

  logic                         is_start, start_ok, div_start, is_last, row_adv;
  logic [1:0][sbag_pkg::QUO_W-1:0] div_num, div_quo;
  logic [1:0][SW-1:0]           div_den;
  logic                         div_busy;
  logic [ACC_W-1:0]             acc_x_sum, acc_y_sum;
  logic [SROW_W-1:0]            srow, scol;
  logic [SMUL_W-1:0]            sprod;
  logic [sbag_pkg::ADDR_W-1:0]  src_addr;
  logic [DROW_W-1:0]            drow, dcol;
  logic [DMUL_W-1:0]            dprod;
  logic [sbag_pkg::ADDR_W-1:0]  dst_addr;
  logic                         gate;

  assign is_start = (in_item.operation == sbag_pkg::OP_START);

  assign start_ok =
      (in_item.src_rect_w != '0) && (in_item.src_rect_h != '0) &&
      (in_item.dst_rect_w != '0) && (in_item.dst_rect_h != '0) &&
      (END_W'(in_item.src_rect_x) + END_W'(in_item.src_rect_w) <= END_W'(cfg.src_w)) &&
      (END_W'(in_item.src_rect_y) + END_W'(in_item.src_rect_h) <= END_W'(cfg.src_h)) &&
      (END_W'(in_item.dst_rect_x) + END_W'(in_item.dst_rect_w) <= END_W'(cfg.dst_w)) &&
      (END_W'(in_item.dst_rect_y) + END_W'(in_item.dst_rect_h) <= END_W'(cfg.dst_h));

  assign div_start  = cmd.accept && is_start && start_ok;
  assign div_num[0] = {in_item.src_rect_w, {FB{1'b0}}};
  assign div_num[1] = {in_item.src_rect_h, {FB{1'b0}}};
  assign div_den[0] = in_item.dst_rect_w;
  assign div_den[1] = in_item.dst_rect_h;

  sbag_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign sts.is_start = is_start;
  assign sts.start_ok = start_ok;
  assign sts.div_busy = div_busy;

  // Destination address of the carried pixel
  assign drow     = DROW_W'(dst_y_r) + DROW_W'(row_cnt_r);
  assign dcol     = DROW_W'(dst_x_r) + DROW_W'(col_cnt_r);
  assign dprod    = DMUL_W'(drow) * DMUL_W'(cfg.dst_w);
  assign dst_addr = sbag_pkg::ADDR_W'(dprod + DMUL_W'(dcol));
  assign gate     = in_item.pixel_in[sbag_pkg::ALPHA_LSB +: sbag_pkg::ALPHA_W] >= cfg.alpha_thr;

  assign is_last   = (col_cnt_r == last_col_r) && (row_cnt_r == last_row_r);
  assign row_adv   = row_cnt_r < last_row_r;
  assign acc_x_sum = ACC_W'(acc_x_r) + ACC_W'(div_quo[0]);
  assign acc_y_sum = ACC_W'(acc_y_r) + ACC_W'(div_quo[1]);

  // Source fetch address from the stepper state after the update
  assign srow     = SROW_W'(src_y_r) + SROW_W'(src_row_r);
  assign scol     = SROW_W'(src_x_r) + SROW_W'(src_col_r);
  assign sprod    = SMUL_W'(srow) * SMUL_W'(cfg.src_w);
  assign src_addr = sbag_pkg::ADDR_W'(sprod + SMUL_W'(scol));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      src_x_r    <= '0;
      src_y_r    <= '0;
      dst_x_r    <= '0;
      dst_y_r    <= '0;
      last_col_r <= '0;
      last_row_r <= '0;
      acc_x_r    <= '0;
      acc_y_r    <= '0;
      src_col_r  <= '0;
      src_row_r  <= '0;
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
    end else if (cmd.accept) begin
      if (is_start) begin
        active_r <= start_ok;
        if (start_ok) begin
          src_x_r    <= in_item.src_rect_x;
          src_y_r    <= in_item.src_rect_y;
          dst_x_r    <= in_item.dst_rect_x;
          dst_y_r    <= in_item.dst_rect_y;
          last_col_r <= in_item.dst_rect_w - 1'b1;
          last_row_r <= in_item.dst_rect_h - 1'b1;
          acc_x_r    <= '0;
          acc_y_r    <= '0;
          src_col_r  <= '0;
          src_row_r  <= '0;
          col_cnt_r  <= '0;
          row_cnt_r  <= '0;
        end
      end else if (active_r) begin
        if (is_last) begin
          active_r <= 1'b0;
        end else if (row_adv) begin
          row_cnt_r <= row_cnt_r + 1'b1;
          acc_y_r   <= acc_y_sum[FB-1:0];
          src_row_r <= src_row_r + sbag_pkg::OFS_W'(acc_y_sum[ACC_W-1:FB]);
        end else begin
          // end of column: vertical stepper restarts
          row_cnt_r <= '0;
          acc_y_r   <= '0;
          src_row_r <= '0;
          col_cnt_r <= col_cnt_r + 1'b1;
          acc_x_r   <= acc_x_sum[FB-1:0];
          src_col_r <= src_col_r + sbag_pkg::OFS_W'(acc_x_sum[ACC_W-1:FB]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (is_start) begin
        res_src_valid_r <= start_ok;
        res_rej_r       <= !start_ok;
        res_last_r      <= 1'b0;
        res_we_r        <= 1'b0;
        res_dst_r       <= '0;
        res_pix_r       <= '0;
      end else if (active_r) begin
        res_src_valid_r <= !is_last;
        res_rej_r       <= 1'b0;
        res_last_r      <= is_last;
        res_we_r        <= gate;
        res_dst_r       <= dst_addr;
        res_pix_r       <= in_item.pixel_in;
      end else begin
        // pixel with no blit running
        res_src_valid_r <= 1'b0;
        res_rej_r       <= 1'b0;
        res_last_r      <= 1'b0;
        res_we_r        <= 1'b0;
        res_dst_r       <= '0;
        res_pix_r       <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.src_addr       <= res_src_valid_r ? src_addr : '0;
      out_r.src_addr_valid <= res_src_valid_r;
      out_r.dst_addr       <= res_dst_r;
      out_r.write_enable   <= res_we_r;
      out_r.pixel_out      <= res_pix_r;
      out_r.last           <= res_last_r;
      out_r.rejected       <= res_rej_r;
    end
  end

  assign out_item = out_r;

endmodule

FILE: sv/sbag_ctrl.sv
// Controller: accepts transactions, waits out the step division, loads the result register.
`timescale 1ns / 1ps

module sbag_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_ready,
  input  sbag_pkg::sts_t sts,
  output logic           in_ready,
  output logic           out_valid,
  output sbag_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_free     = !out_valid_r || out_ready;
  assign cmd.accept   = in_valid && (state_r == S_IDLE);
  assign cmd.load_out = (state_r == S_OUT) && out_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (sts.is_start && sts.start_ok) ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_good_start_divides: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && sts.is_start && sts.start_ok |=> (state_r == S_DIV) && sts.div_busy)
    else $error("accepted start did not enter division");

  a_div_done_outputs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && !sts.div_busy |=> (state_r == S_OUT))
    else $error("division finished but no result step");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r && (state_r == S_IDLE))
    else $error("result load did not raise valid");

  a_held_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && out_valid_r && !out_ready |=> (state_r == S_OUT))
    else $error("result overwrote one not yet taken");

endmodule

FILE: sv/stretch_blit_alpha_gate_unit.sv
// Pixel transaction: counter step and destination multiply, then source address multiply into
//   the result register; a rejected start or an idle pixel takes the same path.
// Accepted start: 29 restoring-divider steps form both ratios, then the controller sees the
//   divider finish before the result step.
// A new transaction is taken only after the previous result is loaded; a waiting result holds.
// Reset: synchronous active-low rst_n; all but the result and divider data registers take their
//   reset values, and the block comes up idle with no blit running and no result pending.
`timescale 1ns / 1ps

module stretch_blit_alpha_gate_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  sbag_in_if.sink                      in_ch,
  sbag_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sbag_pkg::PADDR_W-1:0] paddr,
  input  logic [sbag_pkg::PDATA_W-1:0] pwdata,
  output logic [sbag_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  sbag_pkg::cfg_t      cfg;
  sbag_pkg::in_item_t  in_item;
  sbag_pkg::out_item_t out_item;
  sbag_pkg::cmd_t      cmd;
  sbag_pkg::sts_t      sts;

  assign in_item.operation  = in_ch.operation;
  assign in_item.src_rect_x = in_ch.src_rect_x;
  assign in_item.src_rect_y = in_ch.src_rect_y;
  assign in_item.src_rect_w = in_ch.src_rect_w;
  assign in_item.src_rect_h = in_ch.src_rect_h;
  assign in_item.dst_rect_x = in_ch.dst_rect_x;
  assign in_item.dst_rect_y = in_ch.dst_rect_y;
  assign in_item.dst_rect_w = in_ch.dst_rect_w;
  assign in_item.dst_rect_h = in_ch.dst_rect_h;
  assign in_item.pixel_in   = in_ch.pixel_in;

  assign out_ch.src_addr       = out_item.src_addr;
  assign out_ch.src_addr_valid = out_item.src_addr_valid;
  assign out_ch.dst_addr       = out_item.dst_addr;
  assign out_ch.write_enable   = out_item.write_enable;
  assign out_ch.pixel_out      = out_item.pixel_out;
  assign out_ch.last           = out_item.last;
  assign out_ch.rejected       = out_item.rejected;

  sbag_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sbag_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

  sbag_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

endmodule

FILE: tb/stretch_blit_alpha_gate_unit_tb.sv
// Self-checking testbench: directed table, then random blits, checked against an inline predictor.
`timescale 1ns / 1ps

module stretch_blit_alpha_gate_unit_tb;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 185;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

  typedef struct {
    sbag_pkg::in_item_t  item;
    bit                  typed;
    sbag_pkg::out_item_t want;
  } dir_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [sbag_pkg::PADDR_W-1:0] paddr;
  logic [sbag_pkg::PDATA_W-1:0] pwdata;
  logic [sbag_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  sbag_in_if  in_ch ();
  sbag_out_if out_ch ();

  stretch_blit_alpha_gate_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Blit predictor state
  sbag_pkg::cfg_t                  surf_cfg;
  bit                              blit_on;
  logic [sbag_pkg::COORD_BITS-1:0] blit_sx, blit_sy, blit_dx, blit_dy;
  logic [sbag_pkg::SIZE_W-1:0]     last_col, last_row;
  logic [sbag_pkg::QUO_W-1:0]      step_x, step_y;
  logic [sbag_pkg::ACC_W-1:0]      acc_x, acc_y;
  logic [sbag_pkg::OFS_W-1:0]      src_col_ofs, src_row_ofs;
  logic [sbag_pkg::SIZE_W-1:0]     dst_col_cnt, dst_row_cnt;

  sbag_pkg::out_item_t blit_results_due[$];
  dir_row_t            dir_rows[$];
  int                  mismatches = 0;
  int                  busy_items = 0;
  int                  burst_left = 1;
  int                  idle_cycles = 0;
  int                  stall_phase = 0;
  bit                  sender_gaps = 1'b1;
  stall_mode_t         stall_mode = STALL_RANDOM;
  logic [15:0]         stall_pattern = 16'h5A5B;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [sbag_pkg::ADDR_W-1:0] fetch_addr();
    logic [63:0] row, col, lin;
    row = 64'(blit_sy) + 64'(src_row_ofs);
    col = 64'(blit_sx) + 64'(src_col_ofs);
    lin = row * 64'(surf_cfg.src_w) + col;
    return lin[sbag_pkg::ADDR_W-1:0];
  endfunction

  function automatic sbag_pkg::out_item_t step_blit(sbag_pkg::in_item_t it);
    sbag_pkg::out_item_t r;
    logic [63:0]         sw, sh, dw, dh, dcol, drow, lin;
    r  = '0;
    sw = 64'(it.src_rect_w);
    sh = 64'(it.src_rect_h);
    dw = 64'(it.dst_rect_w);
    dh = 64'(it.dst_rect_h);
    if (it.operation == sbag_pkg::OP_START) begin
      blit_on = 1'b0;
      if (sw == 0 || sh == 0 || dw == 0 || dh == 0 ||
          64'(it.src_rect_x) + sw > 64'(surf_cfg.src_w) ||
          64'(it.src_rect_y) + sh > 64'(surf_cfg.src_h) ||
          64'(it.dst_rect_x) + dw > 64'(surf_cfg.dst_w) ||
          64'(it.dst_rect_y) + dh > 64'(surf_cfg.dst_h)) begin
        r.rejected = 1'b1;
        return r;
      end
      blit_sx     = it.src_rect_x;
      blit_sy     = it.src_rect_y;
      blit_dx     = it.dst_rect_x;
      blit_dy     = it.dst_rect_y;
      last_col    = sbag_pkg::SIZE_W'(dw - 1);
      last_row    = sbag_pkg::SIZE_W'(dh - 1);
      step_x      = sbag_pkg::QUO_W'((sw << sbag_pkg::FRAC_BITS) / dw);
      step_y      = sbag_pkg::QUO_W'((sh << sbag_pkg::FRAC_BITS) / dh);
      acc_x       = '0;
      acc_y       = '0;
      src_col_ofs = '0;
      src_row_ofs = '0;
      dst_col_cnt = '0;
      dst_row_cnt = '0;
      blit_on     = 1'b1;
      r.src_addr       = fetch_addr();
      r.src_addr_valid = 1'b1;
      return r;
    end
    if (!blit_on) return r;
    dcol = 64'(blit_dx) + 64'(dst_col_cnt);
    drow = 64'(blit_dy) + 64'(dst_row_cnt);
    lin  = drow * 64'(surf_cfg.dst_w) + dcol;
    r.dst_addr     = lin[sbag_pkg::ADDR_W-1:0];
    r.write_enable = (it.pixel_in[sbag_pkg::ALPHA_LSB +: sbag_pkg::ALPHA_W] >= surf_cfg.alpha_thr);
    r.pixel_out    = it.pixel_in;
    if (dst_col_cnt == last_col && dst_row_cnt == last_row) begin
      r.last  = 1'b1;
      blit_on = 1'b0;
      return r;
    end
    // walk down the column; vertical stepper restarts at each new column
    if (dst_row_cnt < last_row) begin
      dst_row_cnt = dst_row_cnt + 1'b1;
      acc_y       = acc_y + sbag_pkg::ACC_W'(step_y);
      src_row_ofs = src_row_ofs
                  + sbag_pkg::OFS_W'(acc_y[sbag_pkg::ACC_W-1:sbag_pkg::FRAC_BITS]);
      acc_y       = sbag_pkg::ACC_W'(acc_y[sbag_pkg::FRAC_BITS-1:0]);
    end else begin
      dst_row_cnt = '0;
      src_row_ofs = '0;
      acc_y       = '0;
      dst_col_cnt = dst_col_cnt + 1'b1;
      acc_x       = acc_x + sbag_pkg::ACC_W'(step_x);
      src_col_ofs = src_col_ofs
                  + sbag_pkg::OFS_W'(acc_x[sbag_pkg::ACC_W-1:sbag_pkg::FRAC_BITS]);
      acc_x       = sbag_pkg::ACC_W'(acc_x[sbag_pkg::FRAC_BITS-1:0]);
    end
    r.src_addr       = fetch_addr();
    r.src_addr_valid = 1'b1;
    return r;
  endfunction

  function automatic sbag_pkg::in_item_t noise_item();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(sbag_pkg::in_item_t)-1:0];
  endfunction

  function automatic sbag_pkg::in_item_t mk_start(int sx, int sy, int sw, int sh,
                                                  int dx, int dy, int dw, int dh);
    sbag_pkg::in_item_t it;
    it = noise_item();
    it.operation  = sbag_pkg::OP_START;
    it.src_rect_x = sbag_pkg::COORD_BITS'(sx);
    it.src_rect_y = sbag_pkg::COORD_BITS'(sy);
    it.src_rect_w = sbag_pkg::SIZE_W'(sw);
    it.src_rect_h = sbag_pkg::SIZE_W'(sh);
    it.dst_rect_x = sbag_pkg::COORD_BITS'(dx);
    it.dst_rect_y = sbag_pkg::COORD_BITS'(dy);
    it.dst_rect_w = sbag_pkg::SIZE_W'(dw);
    it.dst_rect_h = sbag_pkg::SIZE_W'(dh);
    return it;
  endfunction

  function automatic sbag_pkg::in_item_t mk_pixel(logic [sbag_pkg::PIX_W-1:0] p);
    sbag_pkg::in_item_t it;
    it = noise_item();
    it.operation = sbag_pkg::OP_PIXEL;
    it.pixel_in  = p;
    return it;
  endfunction

  function automatic sbag_pkg::out_item_t typed_out(int saddr, bit sv, int daddr, bit we,
                                                    logic [sbag_pkg::PIX_W-1:0] pix,
                                                    bit lst, bit rej);
    sbag_pkg::out_item_t r;
    r.src_addr       = sbag_pkg::ADDR_W'(saddr);
    r.src_addr_valid = sv;
    r.dst_addr       = sbag_pkg::ADDR_W'(daddr);
    r.write_enable   = we;
    r.pixel_out      = pix;
    r.last           = lst;
    r.rejected       = rej;
    return r;
  endfunction

  function automatic void add_row(sbag_pkg::in_item_t it, bit typed, sbag_pkg::out_item_t want);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // mostly tiny rectangles, now and then up to the whole surface
  function automatic int pick_size(int limit);
    int cap;
    case ($urandom_range(0, 9)) inside
      [0:5]:   cap = 6;
      [6:8]:   cap = 24;
      default: cap = limit;
    endcase
    if (cap > limit) cap = limit;
    return $urandom_range(1, cap);
  endfunction

  function automatic sbag_pkg::in_item_t good_start();
    int sw, sh, dw, dh;
    sw = pick_size(int'(surf_cfg.src_w));
    sh = pick_size(int'(surf_cfg.src_h));
    dw = pick_size(int'(surf_cfg.dst_w));
    dh = pick_size(int'(surf_cfg.dst_h));
    return mk_start($urandom_range(0, surf_cfg.src_w - sw), $urandom_range(0, surf_cfg.src_h - sh),
                    sw, sh,
                    $urandom_range(0, surf_cfg.dst_w - dw), $urandom_range(0, surf_cfg.dst_h - dh),
                    dw, dh);
  endfunction

  // zero size or one past the surface edge
  function automatic sbag_pkg::in_item_t bad_start();
    sbag_pkg::in_item_t it;
    it = good_start();
    case ($urandom_range(0, 7))
      0:       it.src_rect_w = '0;
      1:       it.src_rect_h = '0;
      2:       it.dst_rect_w = '0;
      3:       it.dst_rect_h = '0;
      4:       it.src_rect_w = sbag_pkg::SIZE_W'(surf_cfg.src_w - it.src_rect_x + 1);
      5:       it.src_rect_h = sbag_pkg::SIZE_W'(surf_cfg.src_h - it.src_rect_y + 1);
      6:       it.dst_rect_w = sbag_pkg::SIZE_W'(surf_cfg.dst_w - it.dst_rect_x + 1);
      default: it.dst_rect_h = sbag_pkg::SIZE_W'(surf_cfg.dst_h - it.dst_rect_y + 1);
    endcase
    return it;
  endfunction

  function automatic logic [sbag_pkg::PIX_W-1:0] pick_pixel();
    logic [sbag_pkg::PIX_W-1:0] p;
    p = $urandom;
    case ($urandom_range(0, 3))
      0:       p[sbag_pkg::ALPHA_LSB +: sbag_pkg::ALPHA_W] = surf_cfg.alpha_thr;
      1:       p[sbag_pkg::ALPHA_LSB +: sbag_pkg::ALPHA_W] = surf_cfg.alpha_thr - 1'b1;
      default: ;
    endcase
    return p;
  endfunction

  task automatic send(sbag_pkg::in_item_t it, bit typed, sbag_pkg::out_item_t want);
    sbag_pkg::out_item_t predicted;
    int                  gap;
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= it.operation;
    in_ch.src_rect_x <= it.src_rect_x;
    in_ch.src_rect_y <= it.src_rect_y;
    in_ch.src_rect_w <= it.src_rect_w;
    in_ch.src_rect_h <= it.src_rect_h;
    in_ch.dst_rect_x <= it.dst_rect_x;
    in_ch.dst_rect_y <= it.dst_rect_y;
    in_ch.dst_rect_w <= it.dst_rect_w;
    in_ch.dst_rect_h <= it.dst_rect_h;
    in_ch.pixel_in   <= it.pixel_in;
    do @(posedge clk); while (!in_ch.ready);
    if (it.operation == sbag_pkg::OP_START || blit_on) busy_items++;
    predicted = step_blit(it);
    blit_results_due.push_back(typed ? want : predicted);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(logic [sbag_pkg::REG_IDX_W-1:0] idx,
                           logic [sbag_pkg::PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      sbag_pkg::REG_SRC_W:     surf_cfg.src_w     = value[sbag_pkg::SURF_W-1:0];
      sbag_pkg::REG_SRC_H:     surf_cfg.src_h     = value[sbag_pkg::SURF_W-1:0];
      sbag_pkg::REG_DST_W:     surf_cfg.dst_w     = value[sbag_pkg::SURF_W-1:0];
      sbag_pkg::REG_DST_H:     surf_cfg.dst_h     = value[sbag_pkg::SURF_W-1:0];
      sbag_pkg::REG_ALPHA_THR: surf_cfg.alpha_thr = value[sbag_pkg::ALPHA_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(string fname, logic [sbag_pkg::PIX_W-1:0] want,
                             logic [sbag_pkg::PIX_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // result side: stall mode set per phase: none, random or a pattern
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      case (stall_mode)
        STALL_NONE:   out_ch.ready <= 1'b1;
        STALL_RANDOM: out_ch.ready <= ($urandom_range(0, 2) != 0);
        default: begin
          out_ch.ready <= stall_pattern[stall_phase];
          stall_phase = (stall_phase + 1) % 16;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    sbag_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (blit_results_due.size() == 0) begin
        $display("%0t: result expected none actual src_addr %h dst_addr %h pixel %h",
                 $time, out_ch.src_addr, out_ch.dst_addr, out_ch.pixel_out);
        mismatches++;
      end else begin
        want = blit_results_due.pop_front();
        check_field("src_addr", sbag_pkg::PIX_W'(want.src_addr),
                    sbag_pkg::PIX_W'(out_ch.src_addr));
        check_field("src_addr_valid", sbag_pkg::PIX_W'(want.src_addr_valid),
                    sbag_pkg::PIX_W'(out_ch.src_addr_valid));
        check_field("dst_addr", sbag_pkg::PIX_W'(want.dst_addr),
                    sbag_pkg::PIX_W'(out_ch.dst_addr));
        check_field("write_enable", sbag_pkg::PIX_W'(want.write_enable),
                    sbag_pkg::PIX_W'(out_ch.write_enable));
        check_field("pixel_out", want.pixel_out, out_ch.pixel_out);
        check_field("last", sbag_pkg::PIX_W'(want.last), sbag_pkg::PIX_W'(out_ch.last));
        check_field("rejected", sbag_pkg::PIX_W'(want.rejected),
                    sbag_pkg::PIX_W'(out_ch.rejected));
      end
    end
  end

  // watchdog: cycles without any transaction or register write
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("stretch_blit_alpha_gate_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    sbag_pkg::out_item_t rej_out;
    sbag_pkg::cfg_t      next_cfg;
    sbag_pkg::in_item_t  it;
    int                  ph, cap, target, pick, npix;
    rst_n            <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= sbag_pkg::OP_START;
    in_ch.src_rect_x <= '0;
    in_ch.src_rect_y <= '0;
    in_ch.src_rect_w <= '0;
    in_ch.src_rect_h <= '0;
    in_ch.dst_rect_x <= '0;
    in_ch.dst_rect_y <= '0;
    in_ch.dst_rect_w <= '0;
    in_ch.dst_rect_h <= '0;
    in_ch.pixel_in   <= '0;

    surf_cfg    = {sbag_pkg::RST_SRC_W, sbag_pkg::RST_SRC_H, sbag_pkg::RST_DST_W,
                   sbag_pkg::RST_DST_H, sbag_pkg::RST_ALPHA_THR};
    blit_on     = 1'b0;
    blit_sx     = '0;
    blit_sy     = '0;
    blit_dx     = '0;
    blit_dy     = '0;
    last_col    = '0;
    last_row    = '0;
    step_x      = '0;
    step_y      = '0;
    acc_x       = '0;
    acc_y       = '0;
    src_col_ofs = '0;
    src_row_ofs = '0;
    dst_col_cnt = '0;
    dst_row_cnt = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset surfaces 640x480 and threshold 255
    rej_out = typed_out(0, 1'b0, 0, 1'b0, '0, 1'b0, 1'b1);
    add_row(mk_pixel(32'hFF00_0000), 1'b1, '0);                 // pixel while idle
    add_row(mk_start(0, 0, 0, 1, 0, 0, 1, 1), 1'b1, rej_out);   // zero source width
    add_row(mk_start(600, 0, 41, 1, 0, 0, 1, 1), 1'b1, rej_out);
    add_row(mk_start(0, 0, 1, 1, 0, 0, 1, 0), 1'b1, rej_out);   // zero destination height
    add_row(mk_start(0, 0, 2, 2, 0, 0, 3, 2), 1'b1,
            typed_out(0, 1'b1, 0, 1'b0, '0, 1'b0, 1'b0));
    add_row(mk_pixel(32'hFF12_3456), 1'b0, '0);
    add_row(mk_pixel(32'hFE00_0001), 1'b0, '0);
    add_row(mk_pixel(32'h00AB_CDEF), 1'b0, '0);
    add_row(mk_pixel(32'hFFFF_FFFF), 1'b0, '0);
    add_row(mk_pixel(32'h7F00_0000), 1'b0, '0);
    add_row(mk_pixel(32'h80FF_FFFF), 1'b0, '0);                 // last of the 3x2 blit
    add_row(mk_pixel(32'h1234_5678), 1'b1, '0);
    add_row(mk_start(639, 479, 1, 1, 639, 479, 1, 1), 1'b1,
            typed_out(307199, 1'b1, 0, 1'b0, '0, 1'b0, 1'b0));
    add_row(mk_pixel(32'hFFFF_FFFF), 1'b1,
            typed_out(0, 1'b0, 307199, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0));
    add_row(mk_start(10, 20, 40, 30, 5, 7, 3, 4), 1'b0, '0);    // downscale
    add_row(mk_pixel(32'hFF00_00FF), 1'b0, '0);
    add_row(mk_pixel(32'h0000_0000), 1'b0, '0);
    add_row(mk_pixel(32'hFFFF_0000), 1'b0, '0);
    add_row(mk_start(0, 0, 1, 4, 100, 100, 2, 8), 1'b0, '0);    // abandons running blit, upscale
    add_row(mk_pixel(32'hFF55_AA55), 1'b0, '0);
    add_row(mk_pixel(32'hFFAA_55AA), 1'b0, '0);
    add_row(mk_start(4095, 4095, 8191, 8191, 4095, 4095, 8191, 8191), 1'b1, rej_out);
    add_row(mk_start(0, 470, 1, 1, 0, 470, 1, 11), 1'b1, rej_out);
    add_row(mk_pixel(32'hFFFF_FFFF), 1'b1, '0);
    foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    for (ph = 0; ph <= PHASES; ph++) begin
      in_ch.valid <= 1'b0;
      while (blit_results_due.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      if (ph == PHASES) break;

      case (ph)
        0: next_cfg = {13'd1, 13'd1, 13'd1, 13'd1, 8'd0};
        1: next_cfg = {13'd4096, 13'd4096, 13'd4096, 13'd4096, 8'($urandom)};
        4: next_cfg = {13'd4096, 13'd1, 13'd1, 13'd4096, 8'd255};
        default: begin
          cap = (ph % 2 != 0) ? 48 : 4096;
          next_cfg.src_w     = sbag_pkg::SURF_W'($urandom_range(1, cap));
          next_cfg.src_h     = sbag_pkg::SURF_W'($urandom_range(1, cap));
          next_cfg.dst_w     = sbag_pkg::SURF_W'($urandom_range(1, cap));
          next_cfg.dst_h     = sbag_pkg::SURF_W'($urandom_range(1, cap));
          next_cfg.alpha_thr = 8'($urandom);
        end
      endcase
      write_reg(sbag_pkg::REG_SRC_W, sbag_pkg::PDATA_W'(next_cfg.src_w));
      write_reg(sbag_pkg::REG_SRC_H, sbag_pkg::PDATA_W'(next_cfg.src_h));
      write_reg(sbag_pkg::REG_DST_W, sbag_pkg::PDATA_W'(next_cfg.dst_w));
      write_reg(sbag_pkg::REG_DST_H, sbag_pkg::PDATA_W'(next_cfg.dst_h));
      write_reg(sbag_pkg::REG_ALPHA_THR, sbag_pkg::PDATA_W'(next_cfg.alpha_thr));

      stall_mode    = stall_mode_t'(ph % 3);
      stall_pattern = 16'($urandom) | 16'h0001;
      sender_gaps   = (ph % 4 != 3);
      if (ph % 4 == 3) stall_mode = STALL_NONE;

      target = busy_items + PHASE_ITEMS;
      while (busy_items < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          // complete blit, sometimes cut short by the next start
          it = good_start();
          send(it, 1'b0, '0);
          npix = int'(it.dst_rect_w) * int'(it.dst_rect_h);
          if (npix > 48 || $urandom_range(0, 6) == 0)
            npix = $urandom_range(0, (npix > 48) ? 48 : npix);
          repeat (npix) send(mk_pixel(pick_pixel()), 1'b0, '0);
        end else if (pick < 84) begin
          send(bad_start(), 1'b0, '0);
        end else if (pick < 92) begin
          send(mk_pixel(pick_pixel()), 1'b0, '0);
        end else begin
          send(noise_item(), 1'b0, '0);
        end
      end
      // leave no blit running across a register write
      if (blit_on) send(bad_start(), 1'b0, '0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && blit_results_due.size() == 0) begin
      $display("stretch_blit_alpha_gate_unit: match");
    end else begin
      $display("stretch_blit_alpha_gate_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/sbag_pkg.sv
sv/sbag_in_if.sv
sv/sbag_out_if.sv
sv/sbag_cfg.sv
sv/sbag_div.sv
sv/sbag_dpath.sv
sv/sbag_ctrl.sv
sv/stretch_blit_alpha_gate_unit.sv
tb/stretch_blit_alpha_gate_unit_tb.sv
